FILE: hw/rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the project.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/gss_pkg.sv
// -----------------------------------------------------------------------------
// Golden-section search package
// Types, codes and fixed-point helpers shared by the search block and its checker.
// -----------------------------------------------------------------------------
`default_nettype none

package gss_pkg;

  // Search phase.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2,
    PH_ITER   = 2'd3
  } phase_t;

  // Input request command, carried in tuser.
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_VALUE = 1'b1
  } cmd_t;

  // Result kind, carried in tuser.
  typedef enum logic [1:0] {
    KIND_PROBE   = 2'd0,
    KIND_MINIMUM = 2'd1,
    KIND_IGNORED = 2'd2
  } kind_t;

  // Configuration register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_RANGE_START = 2'd0,
    REG_RANGE_END   = 2'd1,
    REG_TOLERANCE   = 2'd2
  } reg_idx_t;

  // Golden conjugate and its complement, unsigned Q0.32.
  localparam logic [31:0] RATIO_Q32 = 32'h9E37_79B9;
  localparam logic [31:0] COMPL_Q32 = 32'h61C8_8647;

  localparam logic [31:0] TOL_RESET = 32'd66;

  // Signed product d * r / 2^32, rounded to nearest on the magnitude with
  // ties away from zero.
  function automatic logic signed [33:0] scale_q32(input logic signed [32:0] d,
                                                   input logic [31:0] r);
    logic [32:0] mag;
    logic [64:0] prod;
    logic [32:0] p;
    mag  = d[32] ? 33'(-d) : 33'(d);
    prod = 65'(mag) * 65'(r) + 65'h0_8000_0000;
    p    = prod[64:32];
    return d[32] ? -$signed({1'b0, p}) : $signed({1'b0, p});
  endfunction

  // Saturate a 34-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (!v[33] && (v[32:31] != 2'b00)) begin
      return 32'sh7FFF_FFFF;
    end else if (v[33] && (v[32:31] != 2'b11)) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/golden_section_minimum_search_top.sv
// -----------------------------------------------------------------------------
// Golden-section minimum search
// Steers a partner through a golden-section search and reports the minimum.
// -----------------------------------------------------------------------------
// A request is held in the input register until resolved, its result in the result
// register until taken; a result-side stall holds both, so requests flow at one
// per cycle only while it is absent. Each is resolved in a single pass through one
// shared constant multiplier between the input and result registers.
// Reset (rst, synchronous): search goes idle, interval state clears, and the
// configuration returns to [0, 1.0] with a tolerance of 66 LSBs.
`default_nettype none

module golden_section_minimum_search_top
  import gss_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request stream from the partner.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] func_value
  input  wire logic [0:0]  s_tuser,   // [0] cmd
  // Result stream to the partner.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] point
  output logic [1:0]       m_tuser,   // [1:0] kind
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // The right end of the interval resets to 1.0 in the chosen fixed-point format.
  localparam logic [31:0] RANGE_END_RESET = 32'(64'd1 << FRAC_BITS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] range_start;
  logic signed [31:0] range_end;
  logic [30:0]        tolerance;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= '0;
      range_end   <= RANGE_END_RESET;
      tolerance   <= TOL_RESET[30:0];
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_RANGE_START: range_start <= pwdata;
        REG_RANGE_END:   range_end   <= pwdata;
        REG_TOLERANCE:   tolerance   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_RANGE_START: prdata = range_start;
      REG_RANGE_END:   prdata = range_end;
      REG_TOLERANCE:   prdata = {1'b0, tolerance};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. It takes a new request whenever it is empty or its request
  // is being resolved this cycle, so requests flow at one per cycle unless the
  // result side stalls.
  // ---------------------------------------------------------------------------
  logic        in_vld;
  logic        in_cmd;
  logic [31:0] in_value;
  logic        proc;

  assign proc     = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd   <= s_tuser[0];
      in_value <= s_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Search state
  // ---------------------------------------------------------------------------
  phase_t             phase, phase_next;
  logic signed [31:0] low_bound, high_bound;
  logic signed [31:0] inner_left, inner_right;
  logic signed [31:0] value_left, value_right;
  logic               pending_side;

  logic signed [31:0] low_bound_next, high_bound_next;
  logic signed [31:0] inner_left_next, inner_right_next;
  logic signed [31:0] value_left_next, value_right_next;
  logic               pending_side_next;
  kind_t              res_kind;
  logic signed [31:0] res_point;

  // Values of the two inner points once the arriving function value is filed.
  logic signed [31:0] vl, vr;
  logic               go_right;      // f(x1) > f(x2): the minimum lies right of x1
  logic signed [31:0] lo_n, hi_n;    // narrowed interval
  logic signed [32:0] width;
  logic [32:0]        width_mag;
  logic               converged;
  logic signed [32:0] bound_sum;

  // Shared multiplier operands: the start width or the narrowed width.
  logic signed [32:0] mul_d;
  logic [31:0]        mul_r;
  logic signed [31:0] mul_base;
  logic signed [31:0] new_point;
  logic signed [31:0] start_left;

  always_comb begin
    vl = value_left;
    vr = value_right;
    if (phase == PH_SECOND || (phase == PH_ITER && pending_side)) begin
      vr = in_value;
    end else if (phase == PH_ITER) begin
      vl = in_value;
    end
    go_right  = vl > vr;
    lo_n      = go_right ? inner_left : low_bound;
    hi_n      = go_right ? high_bound : inner_right;
    width     = 33'(hi_n) - 33'(lo_n);
    width_mag = width[32] ? 33'(-width) : 33'(width);
    converged = width_mag < {2'b00, tolerance};
    bound_sum = 33'(lo_n) + 33'(hi_n);
  end

  always_comb begin
    if (in_cmd == CMD_START) begin
      mul_d    = 33'(range_end) - 33'(range_start);
      mul_r    = RATIO_Q32;
      mul_base = range_start;
    end else begin
      mul_d    = width;
      mul_r    = go_right ? RATIO_Q32 : COMPL_Q32;
      mul_base = lo_n;
    end
    new_point  = sat32(34'(mul_base) + scale_q32(mul_d, mul_r));
    // The left point of a fresh search mirrors the right one about the center.
    start_left = sat32(34'(range_start) + 34'(range_end) - 34'(new_point));
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (in_cmd == CMD_START) begin
      phase_next = PH_FIRST;
    end else begin
      unique case (phase)
        PH_IDLE:   phase_next = PH_IDLE;
        PH_FIRST:  phase_next = PH_SECOND;
        PH_SECOND,
        PH_ITER:   phase_next = converged ? PH_IDLE : PH_ITER;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  // Interval update and the result of the request.
  always_comb begin
    low_bound_next    = low_bound;
    high_bound_next   = high_bound;
    inner_left_next   = inner_left;
    inner_right_next  = inner_right;
    value_left_next   = value_left;
    value_right_next  = value_right;
    pending_side_next = pending_side;
    res_kind          = KIND_PROBE;
    res_point         = '0;
    if (in_cmd == CMD_START) begin
      low_bound_next    = range_start;
      high_bound_next   = range_end;
      inner_right_next  = new_point;
      inner_left_next   = start_left;
      pending_side_next = 1'b0;
      res_point         = start_left;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          res_kind = KIND_IGNORED;
        end
        PH_FIRST: begin
          value_left_next   = in_value;
          pending_side_next = 1'b1;
          res_point         = inner_right;
        end
        PH_SECOND, PH_ITER: begin
          value_left_next  = vl;
          value_right_next = vr;
          low_bound_next   = lo_n;
          high_bound_next  = hi_n;
          if (converged) begin
            res_kind  = KIND_MINIMUM;
            res_point = bound_sum[32:1];
          end else if (go_right) begin
            // Old right point becomes the left one; probe a new right point.
            inner_left_next   = inner_right;
            value_left_next   = vr;
            inner_right_next  = new_point;
            pending_side_next = 1'b1;
            res_point         = new_point;
          end else begin
            inner_right_next  = inner_left;
            value_right_next  = vl;
            inner_left_next   = new_point;
            pending_side_next = 1'b0;
            res_point         = new_point;
          end
        end
        default: res_kind = KIND_IGNORED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      low_bound    <= '0;
      high_bound   <= '0;
      inner_left   <= '0;
      inner_right  <= '0;
      value_left   <= '0;
      value_right  <= '0;
      pending_side <= 1'b0;
    end else if (proc) begin
      phase        <= phase_next;
      low_bound    <= low_bound_next;
      high_bound   <= high_bound_next;
      inner_left   <= inner_left_next;
      inner_right  <= inner_right_next;
      value_left   <= value_left_next;
      value_right  <= value_right_next;
      pending_side <= pending_side_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. It holds a result until the partner takes it; a new
  // result is loaded in the same cycle the old one leaves.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      m_tuser <= res_kind;
      m_tdata <= res_point;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gss_checker.sv
// -----------------------------------------------------------------------------
// Golden-section search checker
// Port-level assertions on the search block, attached by a bind statement.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gss_checker
  import gss_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        pready
);

  // A stalled result must hold still until it is taken.
  `ASSERT_CLK(a_result_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // An ignored value request always reports point zero.
  `ASSERT_CLK(a_ignored_zero, clk, rst, m_tvalid && m_tuser == KIND_IGNORED |-> m_tdata == '0, "ignored request with nonzero point")

  // Reset empties the result register.
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result valid right after reset")

  // The configuration port never inserts wait states.
  `ASSERT_CLK(a_no_wait, clk, rst, pready, "configuration port not ready")

endmodule

bind golden_section_minimum_search_top gss_checker u_gss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .pready   (pready)
);

`default_nettype wire

FILE: bench/search_checker.sv
// -----------------------------------------------------------------------------
// Golden-section search checker
// Watches the request, result and register channels of the search block, keeps
// its own copy of the search state and flags every result that differs.
// -----------------------------------------------------------------------------
`default_nettype none

module search_checker
  import gss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] func_value
  input  wire logic [0:0]  s_tuser,   // [0] cmd
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,   // [31:0] point
  input  wire logic [1:0]  m_tuser,   // [1:0] kind
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               mismatch_count,
  output int               open_count
);

  // Golden conjugate and its complement as unsigned Q0.32 fractions.
  localparam logic [63:0] GOLDEN_Q32      = 64'h0000_0000_9E37_79B9;
  localparam logic [63:0] GOLDEN_REST_Q32 = 64'h0000_0000_61C8_8647;
  localparam longint      I32_MAX         = 64'sh0000_0000_7FFF_FFFF;
  localparam longint      I32_MIN         = 64'shFFFF_FFFF_8000_0000;

  typedef struct {
    kind_t       kind;
    logic [31:0] point;
  } answer_t;

  answer_t            promised[$];
  answer_t            oldest;

  logic signed [31:0] cfg_start;
  logic signed [31:0] cfg_end;
  logic [30:0]        cfg_tol;

  phase_t             phase;
  logic signed [31:0] lo_pt, hi_pt;
  logic signed [31:0] left_pt, right_pt;
  logic signed [31:0] left_val, right_val;
  logic               right_pending;

  // Span times a Q0.32 ratio, rounded on the magnitude, ties away from zero.
  function automatic longint golden_cut(input longint span, input logic [63:0] ratio);
    logic [63:0] mag;
    logic [63:0] prod;
    if (span < 0) begin
      mag = -span;
    end else begin
      mag = span;
    end
    prod = (mag * ratio + 64'h8000_0000) >> 32;
    return (span < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic logic signed [31:0] clamp_i32(input longint v);
    if (v > I32_MAX) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < I32_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Moves the search one request forward and queues the result it owes.
  function automatic void advance_search(input cmd_t c, input logic signed [31:0] fv);
    answer_t ans;
    logic    move_low;
    longint  span;
    longint  total;
    ans.kind  = KIND_PROBE;
    ans.point = '0;
    if (c == CMD_START) begin
      lo_pt    = cfg_start;
      hi_pt    = cfg_end;
      right_pt = clamp_i32(longint'(cfg_start) +
                           golden_cut(longint'(cfg_end) - longint'(cfg_start), GOLDEN_Q32));
      left_pt  = clamp_i32(longint'(cfg_start) + longint'(cfg_end) - longint'(right_pt));
      right_pending = 1'b0;
      phase     = PH_FIRST;
      ans.point = left_pt;
    end else if (phase == PH_IDLE) begin
      ans.kind = KIND_IGNORED;
    end else if (phase == PH_FIRST) begin
      left_val      = fv;
      right_pending = 1'b1;
      phase         = PH_SECOND;
      ans.point     = right_pt;
    end else begin
      if (right_pending) begin
        right_val = fv;
      end else begin
        left_val = fv;
      end
      move_low = (left_val > right_val);
      if (move_low) begin
        lo_pt = left_pt;
      end else begin
        hi_pt = right_pt;
      end
      span = longint'(hi_pt) - longint'(lo_pt);
      if (((span < 0) ? -span : span) < longint'({1'b0, cfg_tol})) begin
        total     = longint'(lo_pt) + longint'(hi_pt);
        ans.kind  = KIND_MINIMUM;
        ans.point = 32'(total >>> 1);
        phase     = PH_IDLE;
      end else begin
        if (move_low) begin
          left_pt       = right_pt;
          left_val      = right_val;
          right_pt      = clamp_i32(longint'(lo_pt) + golden_cut(span, GOLDEN_Q32));
          right_pending = 1'b1;
          ans.point     = right_pt;
        end else begin
          right_pt      = left_pt;
          right_val     = left_val;
          left_pt       = clamp_i32(longint'(lo_pt) + golden_cut(span, GOLDEN_REST_Q32));
          right_pending = 1'b0;
          ans.point     = left_pt;
        end
        phase = PH_ITER;
      end
    end
    promised.push_back(ans);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_start      = 32'sd0;
      cfg_end        = 32'sh0001_0000;
      cfg_tol        = 31'd66;
      phase          = PH_IDLE;
      lo_pt          = '0;
      hi_pt          = '0;
      left_pt        = '0;
      right_pt       = '0;
      left_val       = '0;
      right_val      = '0;
      right_pending  = 1'b0;
      mismatch_count = 0;
      promised.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_RANGE_START: cfg_start = pwdata;
          REG_RANGE_END:   cfg_end   = pwdata;
          REG_TOLERANCE:   cfg_tol   = pwdata[30:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        advance_search(cmd_t'(s_tuser[0]), s_tdata);
      end
      if (m_tvalid && m_tready) begin
        if (promised.size() == 0) begin
          $error("unrequested result: kind %0d point %h", m_tuser, m_tdata);
          mismatch_count++;
        end else begin
          oldest = promised.pop_front();
          if (m_tuser !== oldest.kind) begin
            $error("kind mismatch: expected %0d, got %0d", oldest.kind, m_tuser);
            mismatch_count++;
          end
          if (m_tdata !== oldest.point) begin
            $error("point mismatch: expected %h, got %h", oldest.point, m_tdata);
            mismatch_count++;
          end
        end
      end
    end
    open_count = promised.size();
  end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// -----------------------------------------------------------------------------
// Golden-section search testbench
// Drives search requests and register writes into the search block, with
// random gaps and stalls on both streams, and lets the checker judge results.
// -----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import gss_pkg::*;

  // The limit only catches a hung block or a result that never shows up.
  localparam int CYCLE_LIMIT    = 200000;
  localparam int PHASES         = 8;
  localparam int REQS_PER_PHASE = 66;
  localparam int HOLD_CYCLES    = 400;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] func_value
  logic [0:0]  s_tuser;   // [0] cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] point
  logic [1:0]  m_tuser;   // [1:0] kind
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Pacing knobs, in percent of cycles, and the length of a receiver hold-off.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_len;

  int mismatch_count;
  int open_count;
  int cycle_count;

  golden_section_minimum_search_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  search_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .open_count     (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a run that has not finished by the limit is a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result side. Outside of a hold-off, tready is redrawn every cycle from the
  // stall percentage. A hold-off, requested through hold_len and timed here, keeps
  // tready low, so the block backs up while the sender keeps offering requests.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one request, with a random idle gap in front of it, and returns at
  // the falling edge after it was taken. tvalid stays high into the next call,
  // so back-to-back requests never drop it.
  task automatic send_req(input cmd_t c, input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every result owed has been taken. Each
  // request yields exactly one result, so the block is then idle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (open_count != 0) @(negedge clk);
  endtask

  // One register write: setup cycle, access cycle, then a quiet gap so
  // that the next write or request starts on a fresh falling edge.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Function values: mostly random, with the extremes and a cluster of tiny
  // values so that ties between the two inner points happen often.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(3));
      4:       return -32'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  // Picks a search window. The tolerance is mostly tied to the window width
  // so that searches end after a handful to a few dozen probes; inverted and
  // wrapping windows are left in on purpose.
  task automatic choose_window();
    logic [31:0] lo_end;
    logic [31:0] hi_end;
    logic [31:0] span;
    logic [31:0] tol;
    case ($urandom_range(3))
      0: begin
        lo_end = $urandom;
        hi_end = $urandom;
        tol    = $urandom;
      end
      1: begin
        lo_end = $urandom;
        span   = $urandom_range(1, 32'h00FF_FFFF);
        hi_end = lo_end + span;
        tol    = span >> $urandom_range(2, 14);
      end
      2: begin
        lo_end = $urandom;
        span   = $urandom_range(1, 32'h0FFF_FFFF);
        hi_end = lo_end - span;
        tol    = span >> $urandom_range(2, 10);
      end
      default: begin
        lo_end = 32'h0000_0000;
        hi_end = 32'h0001_0000;
        tol    = 32'd66;
      end
    endcase
    if (tol[30:0] == 31'd0) begin
      tol = 32'd1;
    end
    write_reg(REG_RANGE_START, lo_end);
    write_reg(REG_RANGE_END, hi_end);
    write_reg(REG_TOLERANCE, tol);
  endtask

  initial begin
    int sent;
    int burst;
    int roll;
    int pass_idx;

    // Every block input is known from time zero.
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset window [0, 1.0]. Values while idle are ignored,
    // a start in the middle of a search restarts it, and equal values make
    // the compare take the keep-left branch.
    send_req(CMD_VALUE, 32'h7FFF_FFFF);
    send_req(CMD_VALUE, 32'h8000_0000);
    send_req(CMD_START, 32'h0000_0000);
    send_req(CMD_VALUE, 32'd100);
    send_req(CMD_START, 32'hFFFF_FFFF);
    send_req(CMD_VALUE, 32'd7);
    send_req(CMD_VALUE, 32'd7);
    send_req(CMD_VALUE, 32'h8000_0000);
    send_req(CMD_VALUE, 32'h7FFF_FFFF);

    // Widest window with the largest tolerance: the search stops after a
    // couple of compares, and the trailing value lands on an idle block.
    drain();
    write_reg(REG_RANGE_START, 32'h8000_0000);
    write_reg(REG_RANGE_END, 32'h7FFF_FFFF);
    write_reg(REG_TOLERANCE, 32'h7FFF_FFFF);
    send_req(CMD_START, 32'h5555_5555);
    send_req(CMD_VALUE, 32'h7FFF_FFFF);
    send_req(CMD_VALUE, 32'h8000_0000);
    send_req(CMD_VALUE, 32'h0000_0000);
    send_req(CMD_VALUE, 32'h0000_0000);

    // Inverted window: start above end runs through the same arithmetic.
    drain();
    write_reg(REG_RANGE_START, 32'h7FFF_FFFF);
    write_reg(REG_RANGE_END, 32'h8000_0000);
    send_req(CMD_START, 32'hAAAA_AAAA);
    send_req(CMD_VALUE, 32'd1);
    send_req(CMD_VALUE, 32'd2);
    send_req(CMD_VALUE, 32'd3);

    // A tiny window with tolerance 1 can stall: rounding keeps the width from
    // dropping below the tolerance, so probing goes on until the next start.
    drain();
    write_reg(REG_RANGE_START, 32'h0000_0000);
    write_reg(REG_RANGE_END, 32'h0000_0003);
    write_reg(REG_TOLERANCE, 32'h0000_0001);
    send_req(CMD_START, 32'h0000_0000);
    repeat (6) send_req(CMD_VALUE, pick_value());

    // Random part. Each phase gets a fresh window and its own pacing: no
    // idling, sender idle 72%, receiver stalling 72%, both at 34%. Most
    // traffic is a start followed by a run of values; some runs are cut short
    // and some requests are pure noise.
    for (pass_idx = 0; pass_idx < PHASES; pass_idx++) begin
      drain();
      choose_window();
      case (pass_idx % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 72;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 72;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      // With the sender running flat out, a long hold-off on the result side
      // fills the block and pushes back on the request side.
      if (pass_idx == 4) begin
        hold_len = HOLD_CYCLES;
      end
      sent = 0;
      while (sent < REQS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          send_req(cmd_t'($urandom_range(1)), $urandom);
          sent++;
        end else begin
          send_req(CMD_START, $urandom);
          sent++;
          burst = (roll < 22) ? $urandom_range(0, 3) : $urandom_range(4, 36);
          repeat (burst) begin
            send_req(CMD_VALUE, pick_value());
            sent++;
          end
        end
      end
    end

    // Let every owed result come back, then watch the result side for anything
    // stray the block might still put out.
    drain();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && open_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
